### hdl/ppr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the packed palette run-length decoder.
// Used by the parser, the output queue, the top level and the checker; no dependencies.
package ppr_pkg;

    // Parse phases of run-length coding. Any other code acts as the value phase.
    typedef enum logic [2:0] {
        PH_FLAG  = 3'b001,
        PH_COUNT = 3'b010,
        PH_VALUE = 3'b100
    } t_phase;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_RLE     = 2'd1;
    localparam logic [1:0] CFG_COLOR   = 2'd2;
    localparam logic [1:0] CFG_TOTAL   = 2'd3;

    localparam int CFG_DATA_W      = 21;
    localparam int TOTAL_RESET     = 76800;
    localparam int MAX_ENTRIES     = 256;
    localparam int INDEX_W_RESET   = 8;
    localparam int OQ_DEPTH        = 4;
    localparam int OQ_PTR_W        = 2;
    localparam int OQ_CNT_W        = 3;
    localparam int STEPS_PER_BYTE  = 8;

    typedef struct packed {
        logic        command;
        logic [7:0]  data_byte;
        logic [7:0]  palette_index;
        logic [31:0] palette_color;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]  pixel_index;
        logic [31:0] pixel_color;
        logic [8:0]  repeat_res;
        logic        last_of_item;
        logic        image_done;
    } t_pix_out;

    // Decoder settings as seen by the parser.
    typedef struct packed {
        logic [3:0] index_width;
        logic       rle_mode;
        logic       color_mode;
    } t_cfg;

    // Outcome of one bit step, handed from the parser towards the palette and the queue.
    typedef struct packed {
        logic       emit;
        logic       last_step;
        logic       color_mode;
        logic [7:0] index;
        logic [8:0] repeat_res;
        logic       image_done;
    } t_step;

    // Index width from the palette size: bit length of max(1, min(entries, 256) - 1).
    function automatic logic [3:0] f_index_width(input logic [8:0] entries);
        logic [8:0] e;
        logic [7:0] v;
        logic [3:0] w;
        e = (entries > 9'(MAX_ENTRIES)) ? 9'(MAX_ENTRIES) : entries;
        v = (e < 9'd2) ? 8'd1 : 8'(e - 9'd1);
        w = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                w = 4'(i + 1);
            end
        end
        return w;
    endfunction

endpackage

### hdl/ppr_parser.sv
`timescale 1ns / 1ps
// Bit-serial stream parser: holds one data byte and walks it one bit per cycle while queue credit allows.
// Depends on ppr_pkg for the configuration and step types and phase codes.
module ppr_parser
    import ppr_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 21
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  t_pix_in                     i_in_data,
    output logic                        o_in_ready,
    input  logic                        i_credit_ok,
    input  t_cfg                        i_cfg,
    input  logic [PIXEL_COUNT_BITS-1:0] i_total,
    output t_step                       o_step
);

    localparam int CW = (PIXEL_COUNT_BITS > 9) ? PIXEL_COUNT_BITS : 9;

    logic                        r_busy;
    logic [7:0]                  r_byte;
    logic [2:0]                  r_step;
    t_phase                      r_phase, n_phase;
    logic [3:0]                  r_bc, n_bc;
    logic [7:0]                  r_vs, n_vs;
    logic [7:0]                  r_rc, n_rc;
    logic [PIXEL_COUNT_BITS-1:0] r_done, n_done;

    logic                        step_fire;
    logic                        byte_fire;
    logic                        bit_in;
    logic                        active;
    logic                        emit;
    logic [8:0]                  rep_raw;
    logic [8:0]                  rep;
    logic                        done_hit;
    logic [3:0]                  bc_inc;
    logic [7:0]                  vs_sh;
    logic [PIXEL_COUNT_BITS-1:0] remaining;

    assign step_fire  = r_busy && i_credit_ok;
    assign o_in_ready = !r_busy || (step_fire && (r_step == 3'(STEPS_PER_BYTE - 1)));
    assign byte_fire  = i_in_valid && o_in_ready && !i_in_data.command;
    assign bit_in     = r_byte[7];
    assign active     = r_done < i_total;
    assign bc_inc     = r_bc + 4'd1;
    assign vs_sh      = {r_vs[6:0], bit_in};
    assign remaining  = i_total - r_done;

    always_comb begin
        n_phase = r_phase;
        n_bc    = r_bc;
        n_vs    = r_vs;
        n_rc    = r_rc;
        emit    = 1'b0;
        rep_raw = 9'd1;
        if (step_fire && active) begin
            if (i_cfg.color_mode || !i_cfg.rle_mode) begin
                n_vs = vs_sh;
                n_bc = bc_inc;
                if (bc_inc >= i_cfg.index_width) begin
                    emit = 1'b1;
                    n_bc = 4'd0;
                    n_vs = 8'd0;
                end
            end else begin
                case (r_phase)
                    PH_FLAG: begin
                        n_phase = bit_in ? PH_COUNT : PH_VALUE;
                    end
                    PH_COUNT: begin
                        n_rc = {r_rc[6:0], bit_in};
                        n_bc = bc_inc;
                        if (bc_inc >= 4'd8) begin
                            n_phase = PH_VALUE;
                            n_bc    = 4'd0;
                        end
                    end
                    default: begin
                        n_vs = vs_sh;
                        n_bc = bc_inc;
                        if (bc_inc >= i_cfg.index_width) begin
                            emit    = 1'b1;
                            rep_raw = {1'b0, r_rc} + 9'd1;
                            n_bc    = 4'd0;
                            n_vs    = 8'd0;
                            n_rc    = 8'd0;
                            n_phase = PH_FLAG;
                        end
                    end
                endcase
            end
        end
    end

    // A run that would pass the pixel total is clipped to what remains.
    always_comb begin
        done_hit = CW'(rep_raw) >= CW'(remaining);
        rep      = done_hit ? 9'(remaining) : rep_raw;
        n_done   = emit ? (r_done + PIXEL_COUNT_BITS'(rep)) : r_done;
    end

    always_comb begin
        o_step.emit       = emit;
        o_step.last_step  = step_fire && (r_step == 3'(STEPS_PER_BYTE - 1));
        o_step.color_mode = i_cfg.color_mode;
        o_step.index      = vs_sh;
        o_step.repeat_res = rep;
        o_step.image_done = done_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_byte  <= 8'd0;
            r_step  <= 3'd0;
            r_phase <= PH_FLAG;
            r_bc    <= 4'd0;
            r_vs    <= 8'd0;
            r_rc    <= 8'd0;
            r_done  <= '0;
        end else begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_vs    <= n_vs;
            r_rc    <= n_rc;
            r_done  <= n_done;
            if (step_fire) begin
                r_byte <= {r_byte[6:0], 1'b0};
                r_step <= r_step + 3'd1;
                if (r_step == 3'(STEPS_PER_BYTE - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (byte_fire) begin
                r_busy <= 1'b1;
                r_byte <= i_in_data.data_byte;
                r_step <= 3'd0;
            end
        end
    end

endmodule

### hdl/ppr_out_queue.sv
`timescale 1ns / 1ps
// Result assembly and output queue: holds back the newest result until the byte ends
// so that its last flag is known, then queues results for the output channel.
// Depends on ppr_pkg for the step and result types and queue sizes.
module ppr_out_queue
    import ppr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_step       i_s1,
    input  logic [31:0] i_color,
    output logic        o_credit_ok,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_pix_out    o_out_data
);

    t_pix_out              r_fifo [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   r_wp, r_rp;
    logic [OQ_CNT_W-1:0]   r_cnt;
    t_pix_out              r_pend;
    logic                  r_pend_v;

    t_pix_out              fresh;
    t_pix_out              push_data;
    logic                  push;
    logic                  pop;
    logic [OQ_CNT_W:0]     in_flight;

    // Every result still on its way needs a queue slot before another bit step is allowed.
    assign in_flight   = (OQ_CNT_W+1)'(r_cnt) + (OQ_CNT_W+1)'(r_pend_v)
                       + (OQ_CNT_W+1)'(i_s1.emit);
    assign o_credit_ok = in_flight < (OQ_CNT_W+1)'(OQ_DEPTH);

    always_comb begin
        fresh.pixel_index  = i_s1.index;
        fresh.pixel_color  = i_color;
        fresh.repeat_res   = i_s1.repeat_res;
        fresh.last_of_item = i_s1.last_step;
        fresh.image_done   = i_s1.image_done;

        push      = r_pend_v && (r_pend.last_of_item || i_s1.emit || i_s1.last_step);
        push_data = r_pend;
        push_data.last_of_item = r_pend.last_of_item || (i_s1.last_step && !i_s1.emit);
    end

    assign o_out_valid = r_cnt != '0;
    assign o_out_data  = r_fifo[r_rp];
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= push_data;
        end
        if (i_s1.emit) begin
            r_pend <= fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= r_wp + OQ_PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + OQ_PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + OQ_CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - OQ_CNT_W'(1);
            end
            if (i_s1.emit) begin
                r_pend_v <= 1'b1;
            end else if (push) begin
                r_pend_v <= 1'b0;
            end
        end
    end

endmodule

### hdl/packed_palette_rle_decoder_top.sv
`timescale 1ns / 1ps
// Top level of the packed palette run-length decoder: configuration registers,
// palette memory, and the parser and output queue. Depends on ppr_pkg,
// ppr_parser and ppr_out_queue.
//
// The decoder takes a bit-packed sprite stream one byte per transfer and reads each
// byte most significant bit first, one bit per clock cycle while the output queue
// has room, and the next byte is taken in the cycle of the eighth bit. A palette
// write transfer is written straight into the palette memory. Each completed
// index becomes one result transfer; the palette is a synchronous memory read in
// the cycle the index completes, and its data is joined to the result in the next
// cycle. The newest result is held until the byte ends, so that its last-of-item
// flag is known, and results then pass through a four-entry queue; a full queue
// pauses the parser, never the results already decoded. Once the pixel total is
// reached, further stream bits are ignored until reset or a larger total is written.
// The palette has no reset and needs no clearing pass: an entry must be written
// before a color lookup uses it. Configuration is to be written through the plain
// write port while the decoder is idle; the block itself does not enforce this.
// Register 0 is the palette size, 1 the run-length enable, 2 the color expansion
// enable and 3 the pixel total, saturated to the pixel counter.
module packed_palette_rle_decoder_top
    import ppr_pkg::*;
#(
    parameter int PALETTE_DEPTH    = 256,
    parameter int PIXEL_COUNT_BITS = 21
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pix_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_pix_out              o_out_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    // Wide enough for both a written total and the counter's largest value.
    localparam int TW = (PIXEL_COUNT_BITS > CFG_DATA_W) ? PIXEL_COUNT_BITS : CFG_DATA_W;
    localparam logic [TW-1:0] PixMax   = TW'((64'd1 << PIXEL_COUNT_BITS) - 64'd1);
    localparam logic [TW-1:0] TotalRaw = TW'(TOTAL_RESET);
    localparam logic [TW-1:0] TotalRst = (TotalRaw > PixMax) ? PixMax : TotalRaw;

    // Configuration registers.
    t_cfg                        r_cfg;
    logic [PIXEL_COUNT_BITS-1:0] r_total;
    logic [TW-1:0]               wr_total;

    // Palette memory and the pipeline register that waits for its read data.
    logic [31:0]                 r_palette [PALETTE_DEPTH];
    logic [31:0]                 r_rdata;
    t_step                       r_s1;
    logic                        r_s1_in_range;

    t_step                       step;
    logic                        credit_ok;
    logic                        pal_we;
    logic [31:0]                 s1_color;

    assign wr_total = TW'(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.index_width <= 4'(INDEX_W_RESET);
            r_cfg.rle_mode    <= 1'b0;
            r_cfg.color_mode  <= 1'b0;
            r_total           <= PIXEL_COUNT_BITS'(TotalRst);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENTRIES: r_cfg.index_width <= f_index_width(i_cfg_wdata[8:0]);
                CFG_RLE:     r_cfg.rle_mode    <= i_cfg_wdata[0];
                CFG_COLOR:   r_cfg.color_mode  <= i_cfg_wdata[0];
                CFG_TOTAL: begin
                    r_total <= PIXEL_COUNT_BITS'((wr_total > PixMax) ? PixMax : wr_total);
                end
                default: begin
                end
            endcase
        end
    end

    ppr_parser #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .i_credit_ok (credit_ok),
        .i_cfg       (r_cfg),
        .i_total     (r_total),
        .o_step      (step)
    );

    // Palette writes land in the cycle they are accepted. A lookup issued in the same
    // cycle belongs to an earlier byte and correctly sees the old contents.
    assign pal_we = i_in_valid && o_in_ready && i_in_data.command
                 && ({1'b0, i_in_data.palette_index} < 9'(PALETTE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_palette[i_in_data.palette_index[AW-1:0]] <= i_in_data.palette_color;
        end
        r_rdata <= r_palette[step.index[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1          <= '0;
            r_s1_in_range <= 1'b0;
        end else begin
            r_s1          <= step;
            r_s1_in_range <= {1'b0, step.index} < 9'(PALETTE_DEPTH);
        end
    end

    // Indices beyond the palette and plain index mode both give a zero color.
    assign s1_color = (r_s1.color_mode && r_s1_in_range) ? r_rdata : 32'd0;

    ppr_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (r_s1),
        .i_color     (s1_color),
        .o_credit_ok (credit_ok),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### hdl/ppr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the packed palette run-length decoder and its bind.
// Depends on ppr_pkg for the transfer types; attaches to packed_palette_rle_decoder_top.
module ppr_checker
    import ppr_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_pix_out o_out_data
);

    // A result offered on the output stays, unchanged, until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output result dropped or changed while stalled");

    // Reset leaves no result pending and the input open.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("decoder not empty after reset");

    // Every result covers at least one pixel and never more than a full run.
    a_repeat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.repeat_res != 9'd0) && (o_out_data.repeat_res <= 9'd256))
        else $error("repeat count out of range");

    // Once the image completes no further pixel decodes, so the result that completes
    // it is the final one of its byte.
    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.image_done |-> o_out_data.last_of_item)
        else $error("image completed before the end of the byte's results");

endmodule

bind packed_palette_rle_decoder_top ppr_checker u_ppr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
